[design/dcpp_pkg.sv]
// dcpp_pkg: shared constants and types for the smoothed peak-to-peak meter
// no dependencies; used by every module of the block
package dcpp_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int WINDOW_LEN      = 5;
   localparam int HIST_LEN        = 4;
   localparam int PAIRS_BITS      = 3;
   localparam int TOTAL_BITS      = 32;

   // per-word control that travels down the pipeline beside the averages
   typedef struct packed {
      logic last;     // final pair of a frame
      logic restart;  // clear totals before this word
      logic track;    // average belongs to a complete window
      logic first;    // first complete window of the frame
   } ctrl_type;

endpackage

[design/dcpp_lane.sv]
// dcpp_lane: one channel lane, history line, window sum and divide by five
// depends on dcpp_pkg
module dcpp_lane #(
   parameter int SAMPLE_BITS = dcpp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   load,
   input  logic                   advance,
   output logic [SAMPLE_BITS-1:0] average
);

   localparam int SUM_BITS  = SAMPLE_BITS + 3;
   localparam int SHIFT     = SUM_BITS + 3;
   localparam int RECIP_INT = (1 << SHIFT) / dcpp_pkg::WINDOW_LEN + 1;
   localparam int PROD_BITS = 2 * SUM_BITS + 1;
   localparam logic [SUM_BITS:0] RECIP = (SUM_BITS + 1)'(RECIP_INT);

   logic [SAMPLE_BITS-1:0] hist_ff [dcpp_pkg::HIST_LEN];
   logic [SUM_BITS-1:0]    sum_in;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [PROD_BITS-1:0]   product;
   logic [SAMPLE_BITS-1:0] avg_ff;

   // five-point window sum
   always_comb begin
      sum_in = SUM_BITS'(sample);
      for (int k = 0; k < dcpp_pkg::HIST_LEN; k++) begin
         sum_in = sum_in + SUM_BITS'(hist_ff[k]);
      end
   end

   // oldest sample first
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < dcpp_pkg::HIST_LEN; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (load) begin
         for (int k = 0; k < dcpp_pkg::HIST_LEN - 1; k++) begin
            hist_ff[k] <= hist_ff[k+1];
         end
         hist_ff[dcpp_pkg::HIST_LEN-1] <= sample;
      end
   end

   // reciprocal multiply, exact over the whole sum range
   assign product = PROD_BITS'(sum_ff) * PROD_BITS'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
      if (advance) begin
         avg_ff <= product[SHIFT +: SAMPLE_BITS];
      end
   end

   assign average = avg_ff;

endmodule

[design/dcpp_merge.sv]
// dcpp_merge: joins both lanes, tracks peak and trough, totals, output register
// depends on dcpp_pkg
module dcpp_merge #(
   parameter int SAMPLE_BITS = dcpp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  dcpp_pkg::ctrl_type                in_ctrl,
   input  logic [SAMPLE_BITS-1:0]            left_avg,
   input  logic [SAMPLE_BITS-1:0]            right_avg,
   output logic                              in_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [SAMPLE_BITS-1:0]            rsp_left_swing,
   output logic [SAMPLE_BITS-1:0]            rsp_right_swing,
   output logic [dcpp_pkg::TOTAL_BITS-1:0]   rsp_left_total,
   output logic [dcpp_pkg::TOTAL_BITS-1:0]   rsp_right_total
);

   localparam int TB = dcpp_pkg::TOTAL_BITS;

   logic [SAMPLE_BITS-1:0] lpk_ff, lpk_in, ltr_ff, ltr_in;
   logic [SAMPLE_BITS-1:0] rpk_ff, rpk_in, rtr_ff, rtr_in;
   logic [SAMPLE_BITS-1:0] lswing, rswing;
   logic [TB-1:0]          lacc_ff, lacc_in, racc_ff, racc_in;
   logic [SAMPLE_BITS-1:0] lswing_ff, rswing_ff;
   logic [TB-1:0]          ltot_ff, rtot_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   take;

   assign in_ready = !in_ctrl.last || !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      lpk_in = lpk_ff;
      ltr_in = ltr_ff;
      rpk_in = rpk_ff;
      rtr_in = rtr_ff;
      if (in_ctrl.track) begin
         if (in_ctrl.first || left_avg > lpk_ff)  lpk_in = left_avg;
         if (in_ctrl.first || left_avg < ltr_ff)  ltr_in = left_avg;
         if (in_ctrl.first || right_avg > rpk_ff) rpk_in = right_avg;
         if (in_ctrl.first || right_avg < rtr_ff) rtr_in = right_avg;
      end
      // short frame gives zero swing
      lswing = in_ctrl.track ? lpk_in - ltr_in : '0;
      rswing = in_ctrl.track ? rpk_in - rtr_in : '0;
      lacc_in = (in_ctrl.restart ? '0 : lacc_ff) + (in_ctrl.last ? TB'(lswing) : '0);
      racc_in = (in_ctrl.restart ? '0 : racc_ff) + (in_ctrl.last ? TB'(rswing) : '0);
   end

   always_comb begin
      if (take && in_ctrl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         lacc_ff      <= '0;
         racc_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            lacc_ff <= lacc_in;
            racc_ff <= racc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         lpk_ff <= lpk_in;
         ltr_ff <= ltr_in;
         rpk_ff <= rpk_in;
         rtr_ff <= rtr_in;
         if (in_ctrl.last) begin
            lswing_ff <= lswing;
            rswing_ff <= rswing;
            ltot_ff   <= lacc_in;
            rtot_ff   <= racc_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_swing  = lswing_ff;
   assign rsp_right_swing = rswing_ff;
   assign rsp_left_total  = ltot_ff;
   assign rsp_right_total = rtot_ff;

endmodule

[design/dual_channel_smoothed_peak_to_peak.sv]
// a last pair passes the sum, average and output registers before its result shows, unless a stall holds it
// throughput: one sample pair per cycle while rsp_ready keeps up with the frame reports
// a result waiting in the output register stalls a later last pair and the pipe behind it
// reset: synchronous, active high; clears frame count, history, totals and all valid flags
// depends on dcpp_pkg, dcpp_lane and dcpp_merge
module dual_channel_smoothed_peak_to_peak #(
   parameter int SAMPLE_BITS = dcpp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [SAMPLE_BITS-1:0]          req_left_sample,
   input  logic [SAMPLE_BITS-1:0]          req_right_sample,
   input  logic                            req_last_pair,
   input  logic                            req_restart_totals,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [SAMPLE_BITS-1:0]          rsp_left_swing,
   output logic [SAMPLE_BITS-1:0]          rsp_right_swing,
   output logic [dcpp_pkg::TOTAL_BITS-1:0] rsp_left_total,
   output logic [dcpp_pkg::TOTAL_BITS-1:0] rsp_right_total
);

   localparam int PB = dcpp_pkg::PAIRS_BITS;

   // pipeline: accept -> sum stage -> average stage -> merge/output register
   logic                   accept;
   logic                   s1_valid_ff, s1_valid_in, s1_ready, s1_adv;
   logic                   s2_valid_ff, s2_valid_in, s2_ready;
   logic                   merge_ready, merge_take;
   dcpp_pkg::ctrl_type     ctrl_in, s1_ctrl_ff, s2_ctrl_ff;
   logic [PB-1:0]          pairs_ff, pairs_in;
   logic [SAMPLE_BITS-1:0] left_avg, right_avg;

   // ready ripples back from the merge stage
   assign s2_ready   = !s2_valid_ff || merge_ready;
   assign s1_adv     = s1_valid_ff && s2_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_ready  = s1_ready;
   assign accept     = req_valid && req_ready;
   assign merge_take = s2_valid_ff && merge_ready;

   // frame pair count, saturating once a full window has been seen
   always_comb begin
      ctrl_in.last    = req_last_pair;
      ctrl_in.restart = req_restart_totals;
      ctrl_in.track   = (pairs_ff >= PB'(dcpp_pkg::HIST_LEN));
      ctrl_in.first   = (pairs_ff == PB'(dcpp_pkg::HIST_LEN));
      if (req_last_pair) begin
         pairs_in = '0;
      end else if (pairs_ff < PB'(dcpp_pkg::WINDOW_LEN)) begin
         pairs_in = pairs_ff + PB'(1);
      end else begin
         pairs_in = pairs_ff;
      end
   end

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in = s1_adv ? 1'b1 : (merge_take ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pairs_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (accept) begin
            pairs_ff <= pairs_in;
         end
      end
   end

   // control rides alongside the lane data
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= ctrl_in;
      end
      if (s1_adv) begin
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   // history of the earlier frame only feeds averages that are never tracked
   dcpp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_left_lane (
      .clock   (clock),
      .reset   (reset),
      .sample  (req_left_sample),
      .load    (accept),
      .advance (s1_adv),
      .average (left_avg)
   );

   dcpp_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_right_lane (
      .clock   (clock),
      .reset   (reset),
      .sample  (req_right_sample),
      .load    (accept),
      .advance (s1_adv),
      .average (right_avg)
   );

   // peak/trough tracking, totals and the output register
   dcpp_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s2_valid_ff),
      .in_ctrl         (s2_ctrl_ff),
      .left_avg        (left_avg),
      .right_avg       (right_avg),
      .in_ready        (merge_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_swing  (rsp_left_swing),
      .rsp_right_swing (rsp_right_swing),
      .rsp_left_total  (rsp_left_total),
      .rsp_right_total (rsp_right_total)
   );

endmodule

[design/dcpp_checker.sv]
// dcpp_assert: port-level checks on the smoothed peak-to-peak meter
// depends on dcpp_pkg; bound to dual_channel_smoothed_peak_to_peak
module dcpp_assert #(
   parameter int SAMPLE_BITS = dcpp_pkg::SAMPLE_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [SAMPLE_BITS-1:0]          req_left_sample,
   input logic [SAMPLE_BITS-1:0]          req_right_sample,
   input logic                            req_last_pair,
   input logic                            req_restart_totals,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [SAMPLE_BITS-1:0]          rsp_left_swing,
   input logic [SAMPLE_BITS-1:0]          rsp_right_swing,
   input logic [dcpp_pkg::TOTAL_BITS-1:0] rsp_left_total,
   input logic [dcpp_pkg::TOTAL_BITS-1:0] rsp_right_total
);

   // a waiting result holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_swing)
         && $stable(rsp_right_swing) && $stable(rsp_left_total)
         && $stable(rsp_right_total))
      else $error("result word changed while stalled");

   // an offered sample pair stays put until it is taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_left_sample)
         && $stable(req_right_sample) && $stable(req_last_pair)
         && $stable(req_restart_totals))
      else $error("input word changed while stalled");

   // reset leaves the pipe empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // with the output register free nothing can back up to the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

endmodule

bind dual_channel_smoothed_peak_to_peak dcpp_assert #(.SAMPLE_BITS(SAMPLE_BITS))
   u_dcpp_assert (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_left_sample    (req_left_sample),
   .req_right_sample   (req_right_sample),
   .req_last_pair      (req_last_pair),
   .req_restart_totals (req_restart_totals),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_left_swing     (rsp_left_swing),
   .rsp_right_swing    (rsp_right_swing),
   .rsp_left_total     (rsp_left_total),
   .rsp_right_total    (rsp_right_total)
);
